### hw/rtl/dcs_pkg.sv
// Shared constants, types and helper functions of the discrete CDF sampler.
package dcs_pkg;

    localparam int MAX_ENTRIES = 256;
    localparam int WEIGHT_BITS = 16;

    localparam int IDX_W    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W    = $clog2(MAX_ENTRIES + 1);
    localparam int STEP_W   = $clog2(CNT_W + 1);
    localparam int CFG_W    = 9;
    localparam int WEIGHT_W = 16;
    localparam int UNI_W    = 17;
    localparam int TOTAL_W  = 24;
    localparam int OUT_W    = 8;

    localparam logic [CFG_W-1:0]    CFG_RESET   = CFG_W'(256);
    localparam logic [TOTAL_W-1:0]  TOTAL_MAX   = '1;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MASK = (WEIGHT_BITS >= WEIGHT_W) ? '1 :
                                                  WEIGHT_W'((64'd1 << WEIGHT_BITS) - 64'd1);

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_DRAW = 1'b1;

    typedef struct packed {
        logic init;
        logic load;
        logic step;
    } t_dcs_cmd;

    typedef struct packed {
        logic [STEP_W-1:0] steps;
    } t_dcs_status;

    // Number of halving steps: position of the leading one plus one.
    function automatic logic [STEP_W-1:0] halving_steps(input logic [CNT_W-1:0] n);
        logic [STEP_W-1:0] pos;
        pos = '0;
        for (int i = 0; i < CNT_W; i++) begin
            if (n[i]) begin
                pos = STEP_W'(i);
            end
        end
        return pos + STEP_W'(1);
    endfunction

endpackage

### hw/rtl/discrete_cdf_sampler_top.sv
// Top level of the discrete CDF sampler: controller and datapath joined.
//
// Usage. An item is transferred on the rising edge at which start is high and
// busy is low. With i_command low it is a load: the running sum of earlier
// weights is stored into the next table slot and i_weight is added to it.
// Loads never raise busy, so one can be transferred in every idle cycle. With
// i_command high it is a draw: a binary search over the cumulative table for
// the last entry not above i_uniform. Busy stays high from the transfer of a
// draw through the first state and each halving step of the search, and
// o_strobe, for a single cycle, the one in which busy falls, marks the result
// on o_sample_index; a new item may be transferred in that cycle, so a draw
// is finished before the next item is taken. The search loop does one table
// read per halving step through the registered read port of the table RAM,
// with the compare and the next address formed in the same cycle.
// The receiver cannot stall: each result must be taken in its strobe cycle.
// Reset (synchronous, active low) empties the table, clears the load slot
// and the running sum, and sets the entry count to 256; no clearing pass is
// needed, as per-entry valid bits make unloaded entries read as zero.
// The entry count is written through i_cfg_wr_en / i_cfg_wr_data; the user
// must do so only while the block is idle, which the block does not enforce.
module discrete_cdf_sampler_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_command,
    input  logic [dcs_pkg::WEIGHT_W-1:0]  i_weight,
    input  logic [dcs_pkg::UNI_W-1:0]     i_uniform,
    output logic                          o_strobe,
    output logic [dcs_pkg::OUT_W-1:0]     o_sample_index,
    input  logic                          i_cfg_wr_en,
    input  logic [dcs_pkg::CFG_W-1:0]     i_cfg_wr_data
);
    import dcs_pkg::*;

    t_dcs_cmd    cmd;
    t_dcs_status status;

    // The controller sequences one draw at a time and issues commands.
    dcs_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_command (i_command),
        .i_status  (status),
        .o_cmd     (cmd),
        .busy      (busy),
        .o_strobe  (o_strobe)
    );

    // The datapath holds the table, the loader and the search bounds.
    dcs_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_weight       (i_weight),
        .i_uniform      (i_uniform),
        .o_sample_index (o_sample_index)
    );

endmodule

### hw/rtl/dcs_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module dcs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                             i_clk,
    input  logic                             i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]         i_wr_addr,
    input  logic [WIDTH-1:0]                 i_wr_data,
    input  logic [$clog2(DEPTH)-1:0]         i_rd_addr,
    output logic [WIDTH-1:0]                 o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/dcs_ctrl.sv
// Controller state machine of the discrete CDF sampler.
module dcs_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  logic                 i_command,
    input  dcs_pkg::t_dcs_status i_status,
    output dcs_pkg::t_dcs_cmd    o_cmd,
    output logic                 busy,
    output logic                 o_strobe
);
    import dcs_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_FIRST  = 3'b010,
        ST_SEARCH = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_count, n_count;
    logic              r_strobe, n_strobe;
    logic              accept;

    assign accept     = start && (r_state == ST_IDLE);
    assign o_cmd.load = accept && (i_command == CMD_LOAD);
    assign o_cmd.init = accept && (i_command == CMD_DRAW);
    assign o_cmd.step = (r_state == ST_SEARCH);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_strobe = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (o_cmd.init) begin
                    n_state = ST_FIRST;
                    n_count = i_status.steps;
                end
            end
            ST_FIRST: begin
                n_state = ST_SEARCH;
            end
            ST_SEARCH: begin
                n_count = r_count - STEP_W'(1);
                if (r_count == STEP_W'(1)) begin
                    n_state  = ST_IDLE;
                    n_strobe = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;

endmodule

### hw/rtl/dcs_datapath.sv
// Datapath of the discrete CDF sampler: table, loader and search registers.
module dcs_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dcs_pkg::t_dcs_cmd             i_cmd,
    output dcs_pkg::t_dcs_status          o_status,
    input  logic                          i_cfg_wr_en,
    input  logic [dcs_pkg::CFG_W-1:0]     i_cfg_wr_data,
    input  logic [dcs_pkg::WEIGHT_W-1:0]  i_weight,
    input  logic [dcs_pkg::UNI_W-1:0]     i_uniform,
    output logic [dcs_pkg::OUT_W-1:0]     o_sample_index
);
    import dcs_pkg::*;

    logic [CFG_W-1:0]       r_entries;
    logic [IDX_W-1:0]       r_load_slot, n_load_slot;
    logic [TOTAL_W-1:0]     r_total, n_total;
    logic [MAX_ENTRIES-1:0] r_valid;
    logic [UNI_W-1:0]       r_uniform;
    logic [CNT_W-1:0]       r_low, r_high;
    logic [IDX_W-1:0]       r_mid;

    logic [CNT_W-1:0]       n_active;
    logic                   slot_wrap;
    logic [IDX_W-1:0]       eff_slot;
    logic [TOTAL_W-1:0]     eff_total;
    logic [TOTAL_W:0]       sum;
    logic [TOTAL_W-1:0]     sat_total;
    logic [CNT_W-1:0]       slot_next;

    logic [TOTAL_W-1:0]     ram_q;
    logic [TOTAL_W-1:0]     entry;
    logic                   hit;
    logic [CNT_W-1:0]       step_low, step_high;
    logic [CNT_W:0]         mid_sum;
    logic [CNT_W-1:0]       mid_raw;
    logic [IDX_W-1:0]       mid;

    // Effective entry count: zero acts as one, oversize acts as the table depth.
    always_comb begin
        if (r_entries == '0) begin
            n_active = CNT_W'(1);
        end else if (32'(r_entries) > 32'(MAX_ENTRIES)) begin
            n_active = CNT_W'(MAX_ENTRIES);
        end else begin
            n_active = CNT_W'(r_entries);
        end
    end

    assign o_status.steps = halving_steps(n_active);

    // Loader: wrap first if the count shrank, store the old sum, saturate.
    always_comb begin
        slot_wrap = (CNT_W'(r_load_slot) >= n_active);
        eff_slot  = slot_wrap ? '0 : r_load_slot;
        eff_total = slot_wrap ? '0 : r_total;
        sum       = {1'b0, eff_total} + (TOTAL_W + 1)'(i_weight & WEIGHT_MASK);
        sat_total = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
        slot_next = CNT_W'(eff_slot) + CNT_W'(1);
        if (slot_next >= n_active) begin
            n_load_slot = '0;
            n_total     = '0;
        end else begin
            n_load_slot = IDX_W'(slot_next);
            n_total     = sat_total;
        end
    end

    // Search step: entries never loaded since reset read as zero.
    always_comb begin
        entry = r_valid[r_mid] ? ram_q : '0;
        hit   = (entry <= TOTAL_W'(r_uniform));
        if (i_cmd.step) begin
            step_low  = hit ? CNT_W'(r_mid) : r_low;
            step_high = hit ? r_high : CNT_W'(r_mid);
        end else begin
            step_low  = r_low;
            step_high = r_high;
        end
        mid_sum = (CNT_W + 1)'(step_low) + (CNT_W + 1)'(step_high);
        mid_raw = CNT_W'(mid_sum >> 1);
        mid     = (mid_raw >= CNT_W'(MAX_ENTRIES)) ? IDX_W'(MAX_ENTRIES - 1)
                                                   : IDX_W'(mid_raw);
    end

    dcs_ram #(
        .WIDTH (TOTAL_W),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.load),
        .i_wr_addr (eff_slot),
        .i_wr_data (eff_total),
        .i_rd_addr (mid),
        .o_rd_data (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries   <= CFG_RESET;
            r_load_slot <= '0;
            r_total     <= '0;
            r_valid     <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_entries <= i_cfg_wr_data;
            end
            if (i_cmd.load) begin
                r_load_slot       <= n_load_slot;
                r_total           <= n_total;
                r_valid[eff_slot] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mid <= mid;
        if (i_cmd.init) begin
            r_uniform <= i_uniform;
            r_low     <= '0;
            r_high    <= n_active;
        end else if (i_cmd.step) begin
            r_low  <= step_low;
            r_high <= step_high;
        end
    end

    assign o_sample_index = OUT_W'(r_low);

endmodule

### hw/rtl/dcs_checker.sv
// Port-level checks of the discrete CDF sampler, bound to the top level.
module dcs_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_command,
    input logic o_strobe
);
    import dcs_pkg::*;

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while busy");

    a_draw_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_command == CMD_DRAW)) |=> busy)
        else $error("draw transfer did not raise busy");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_command == CMD_LOAD)) |=> (!busy && !o_strobe))
        else $error("load transfer raised busy or a result");

    a_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_strobe)
        else $error("draw ended without a result");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe longer than one cycle");

endmodule

bind discrete_cdf_sampler_top dcs_checker u_dcs_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .start     (start),
    .busy      (busy),
    .i_command (i_command),
    .o_strobe  (o_strobe)
);

### test/discrete_cdf_sampler_top_tb.sv
// Self-checking testbench of the discrete CDF sampler top level.
`timescale 1ns / 100ps

module discrete_cdf_sampler_top_tb;

    import dcs_pkg::*;

    // Cycles allowed for the block to settle once the last result has come.
    localparam int SETTLE_CYCLES = 16;
    // At most some twelve hundred items are sent, since the last random phase
    // may fill a whole table; even with the phase drains, the run stays far
    // below this limit.
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_ITEMS  = 900;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic                i_command = CMD_LOAD;
    logic [WEIGHT_W-1:0] i_weight = '0;
    logic [UNI_W-1:0]    i_uniform = '0;
    logic                o_strobe;
    logic [OUT_W-1:0]    o_sample_index;
    logic                i_cfg_wr_en = 1'b0;
    logic [CFG_W-1:0]    i_cfg_wr_data = '0;

    discrete_cdf_sampler_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_weight       (i_weight),
        .i_uniform      (i_uniform),
        .o_strobe       (o_strobe),
        .o_sample_index (o_sample_index),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Our own copy of the block's state: the cumulative table, the slot that
    // the next load fills, the sum of weights since the last wrap, and the
    // entry count register.
    logic [TOTAL_W-1:0] cdf_table [MAX_ENTRIES];
    int                 next_slot;
    logic [TOTAL_W-1:0] weight_sum;
    logic [CFG_W-1:0]   entry_count;

    // Indices that the draws transferred so far should yield, oldest first.
    logic [OUT_W-1:0]   pending_index [$];

    int error_count   = 0;
    int cycle_count   = 0;
    int loads_sent    = 0;
    int draws_sent    = 0;
    int results_seen  = 0;
    int config_writes = 0;

    // The register is clamped into the range 1 to MAX_ENTRIES before use.
    function automatic int active_entries();
        int n;
        n = int'(entry_count);
        if (n < 1) n = 1;
        if (n > MAX_ENTRIES) n = MAX_ENTRIES;
        return n;
    endfunction

    function automatic void clear_model();
        for (int i = 0; i < MAX_ENTRIES; i++) cdf_table[i] = '0;
        next_slot   = 0;
        weight_sum  = '0;
        entry_count = CFG_RESET;
    endfunction

    // A load stores the sum before it, then adds its own weight with
    // saturation. Loading wraps, with the sum cleared, when the slot runs off
    // the end of the table, including when the table has been shrunk under it.
    function automatic void accumulate_weight(input logic [WEIGHT_W-1:0] w);
        int               n;
        logic [TOTAL_W:0] wide_sum;
        n = active_entries();
        if (next_slot >= n) begin
            next_slot  = 0;
            weight_sum = '0;
        end
        cdf_table[next_slot] = weight_sum;
        wide_sum   = {1'b0, weight_sum} + (TOTAL_W + 1)'(w & WEIGHT_MASK);
        weight_sum = (wide_sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : wide_sum[TOTAL_W-1:0];
        next_slot++;
        if (next_slot >= n) begin
            next_slot  = 0;
            weight_sum = '0;
        end
    endfunction

    // Binary search for the last entry not above the uniform value, run for
    // floor(log2 N) + 1 halving steps over [0, N).
    function automatic logic [OUT_W-1:0] search_index(input logic [UNI_W-1:0] u);
        int n;
        int lo;
        int hi;
        int mid;
        int steps;
        int t;
        n     = active_entries();
        lo    = 0;
        hi    = n;
        steps = 1;
        t     = n;
        while (t > 1) begin
            t = t >> 1;
            steps++;
        end
        for (int s = 0; s < steps; s++) begin
            mid = (lo + hi) >> 1;
            if (mid >= MAX_ENTRIES) mid = MAX_ENTRIES - 1;
            if (cdf_table[mid] <= TOTAL_W'(u)) lo = mid;
            else hi = mid;
        end
        return OUT_W'(lo);
    endfunction

    // Every result must match the oldest outstanding draw. Outputs are read
    // at the edge, so the values seen are those held during the strobe cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe === 1'b1) begin
            results_seen++;
            if (pending_index.size() == 0) begin
                error_count++;
                $display("%0t: result %0d arrived with no draw outstanding",
                         $time, o_sample_index);
            end else begin
                if (o_sample_index !== pending_index[0]) begin
                    error_count++;
                    $display("%0t: sample_index mismatch: expected %0d, actual %0d",
                             $time, pending_index[0], o_sample_index);
                end
                void'(pending_index.pop_front());
            end
        end
    end

    // Cycle counter that ends a run which has hung.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles with %0d results outstanding",
                 cycle_count, pending_index.size());
        $display("*** FAILED ***");
        $finish;
    end

    // Sends one item. The caller is always just past a rising edge. A random gap
    // may come first; with no gap, start stays high straight on from the previous
    // transfer. The transfer happens at the first edge at which busy is low, and
    // the prediction is made there.
    task automatic send_item(input logic cmd, input logic [WEIGHT_W-1:0] w,
                             input logic [UNI_W-1:0] u);
        int gap;
        gap = $urandom_range(0, 5);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start     <= 1'b1;
        i_command <= cmd;
        i_weight  <= w;
        i_uniform <= u;
        do begin
            @(posedge i_clk);
        end while (busy !== 1'b0);
        if (cmd == CMD_LOAD) begin
            accumulate_weight(w);
            loads_sent++;
        end else begin
            pending_index.push_back(search_index(u));
            draws_sent++;
        end
    endtask

    // Holds the sender off until every outstanding result has come, then
    // lets the block settle so that no load is still in flight.
    task automatic drain_block();
        start <= 1'b0;
        while (pending_index.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes the entry count; only called once the block has drained.
    task automatic write_entry_count(input logic [CFG_W-1:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        entry_count = value;
        config_writes++;
    endtask

    // Weights scaled so that the table sum sits near one, with the extremes
    // and full-range values mixed in.
    function automatic logic [WEIGHT_W-1:0] pick_weight(input int n);
        int r;
        int top;
        r = $urandom_range(0, 7);
        case (r)
            0: return '0;
            1: return '1;
            2: return WEIGHT_W'($urandom);
            default: begin
                top = 131072 / n;
                if (top > 65535) top = 65535;
                return WEIGHT_W'($urandom_range(0, top));
            end
        endcase
    endfunction

    // Uniform values: the ends, values above one, plain random values, and
    // values just either side of a table entry so that every comparison
    // boundary gets hit.
    function automatic logic [UNI_W-1:0] pick_uniform(input int n);
        int r;
        int k;
        int target;
        r = $urandom_range(0, 7);
        case (r)
            0: return '0;
            1: return UNI_W'(65536);
            2: return '1;
            3, 4: return UNI_W'($urandom);
            default: begin
                k      = $urandom_range(0, n - 1);
                target = int'(cdf_table[k]) + $urandom_range(0, 2) - 1;
                if (target < 0 || target > 131071) return UNI_W'($urandom);
                return UNI_W'(target);
            end
        endcase
    endfunction

    // A draw straight after reset searches an all-zero table, so every
    // comparison passes and the search ends on the last entry.
    task automatic test_empty_table();
        send_item(CMD_DRAW, '0, '0);
        send_item(CMD_DRAW, '0, UNI_W'(65536));
        drain_block();
    endtask

    // A small table with zero and full-scale weights, drawn at zero, exactly
    // one, the top of the field and on an entry.
    task automatic test_small_distribution();
        write_entry_count(CFG_W'(4));
        send_item(CMD_LOAD, '0, '0);
        send_item(CMD_LOAD, '1, '0);
        send_item(CMD_LOAD, WEIGHT_W'(1), '0);
        send_item(CMD_LOAD, WEIGHT_W'(16'h8000), '0);
        send_item(CMD_DRAW, '0, '0);
        send_item(CMD_DRAW, '0, UNI_W'(65535));
        send_item(CMD_DRAW, '0, UNI_W'(65536));
        send_item(CMD_DRAW, '0, '1);
        drain_block();
    endtask

    // A count of zero behaves as one entry, and counts above the table size
    // behave as the full table, which still holds older loads.
    task automatic test_register_limits();
        write_entry_count('0);
        send_item(CMD_LOAD, '1, '0);
        send_item(CMD_DRAW, '0, UNI_W'(100));
        drain_block();
        write_entry_count('1);
        send_item(CMD_DRAW, '0, '0);
        send_item(CMD_DRAW, '0, '1);
        drain_block();
        write_entry_count(CFG_W'(257));
        send_item(CMD_DRAW, '0, UNI_W'(65536));
        drain_block();
    endtask

    // Shrinking the table below the load slot makes the next load wrap to
    // the first slot with the sum cleared.
    task automatic test_shrink_while_loading();
        write_entry_count(CFG_W'(8));
        repeat (5) send_item(CMD_LOAD, WEIGHT_W'($urandom_range(1000, 9000)), '0);
        drain_block();
        write_entry_count(CFG_W'(3));
        send_item(CMD_LOAD, WEIGHT_W'(20000), '0);
        send_item(CMD_LOAD, WEIGHT_W'(30000), '0);
        send_item(CMD_DRAW, '0, UNI_W'(20000));
        send_item(CMD_DRAW, '0, UNI_W'(19999));
        drain_block();
    endtask

    // Random phases. Each phase picks an entry count, mostly small with the
    // extremes now and then, drains the block and writes it. Most phases
    // fill the whole table and then draw from it; the rest are a loose mix
    // of loads and draws that leave the table partly reloaded.
    task automatic test_random_traffic();
        int target;
        int r;
        int n;
        int draws;
        int mix;
        target = loads_sent + draws_sent + RANDOM_ITEMS;
        while (loads_sent + draws_sent < target) begin
            r = $urandom_range(0, 11);
            case (r)
                0:       n = 256;
                1:       n = 0;
                2:       n = $urandom_range(257, 511);
                3:       n = $urandom_range(33, 255);
                4:       n = $urandom_range(1, 2);
                default: n = $urandom_range(1, 32);
            endcase
            drain_block();
            write_entry_count(CFG_W'(n));
            n = active_entries();
            if ($urandom_range(0, 4) != 0) begin
                repeat (n) send_item(CMD_LOAD, pick_weight(n), '0);
                draws = $urandom_range(3, 12);
                repeat (draws) send_item(CMD_DRAW, WEIGHT_W'($urandom), pick_uniform(n));
            end else begin
                mix = $urandom_range(1, 20);
                repeat (mix) begin
                    if ($urandom_range(0, 1) == 0)
                        send_item(CMD_LOAD, pick_weight(n), UNI_W'($urandom));
                    else
                        send_item(CMD_DRAW, WEIGHT_W'($urandom), pick_uniform(n));
                end
            end
        end
        drain_block();
    endtask

    initial begin
        clear_model();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_small_distribution();
        test_register_limits();
        test_shrink_while_loading();
        test_random_traffic();

        // Everything has drained; give the block a final settling period and
        // make sure nothing is left waiting.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_index.size() != 0) begin
            error_count++;
            $display("%0t: %0d draws never produced a result", $time, pending_index.size());
        end

        $display("Run covered %0d loads and %0d draws over %0d entry-count settings;",
                 loads_sent, draws_sent, config_writes);
        $display("%0d results were compared, with %0d errors.", results_seen, error_count);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
